// File: rtl/shacal2_block_cipher_cbc_defines.svh
// assertion macros for the shacal-2 cbc block
// used by the modules that carry concurrent checks
`ifndef SHACAL2_BLOCK_CIPHER_CBC_DEFINES_SVH
`define SHACAL2_BLOCK_CIPHER_CBC_DEFINES_SVH
`ifndef SYNTH
`define SHA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("assert");
`define SHA_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assert");
`else
`define SHA_ASSERT(lbl, clk, rstn, prop)
`define SHA_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// File: rtl/sha2c_pkg.sv
// package for the shacal-2 cbc block: types, round constants, round functions
// no dependencies
`timescale 1ns / 1ps
package sha2c_pkg;
  localparam int NumRounds = 64;
  localparam int NumKeyRegs = 8;
  localparam int RndW = 6;
  localparam int KeyIdxW = 3;

  typedef struct packed {
    logic        dec;
    logic        cbc;
    logic        start;
    logic [63:0] d0, d1, d2, d3;
    logic [63:0] v0, v1, v2, v3;
  } cmd_t;

  localparam int CmdW = $bits(cmd_t);

  function automatic logic [31:0] rc(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
          32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
          32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
          32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
          32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
          32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
          32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
          32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
          32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
          32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
          32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
          32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
          32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
          32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
          32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
          32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[i];
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction
  function automatic logic [31:0] bs0(input logic [31:0] x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction
  function automatic logic [31:0] bs1(input logic [31:0] x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction
  function automatic logic [31:0] ss0(input logic [31:0] x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction
  function automatic logic [31:0] ss1(input logic [31:0] x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction
  function automatic logic [31:0] ch(input logic [31:0] x, y, z);
    return (x & y) ^ (~x & z);
  endfunction
  function automatic logic [31:0] maj(input logic [31:0] x, y, z);
    return (x & y) ^ (x & z) ^ (y & z);
  endfunction
endpackage

// File: rtl/sha2c_front.sv
// front end: accepts beats into a two-entry command queue
// depends on sha2c_pkg
`timescale 1ns / 1ps
module sha2c_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sha2c_pkg::cmd_t   cmd_i,
  output logic              q_valid_o,
  input  logic              q_pop_i,
  output sha2c_pkg::cmd_t   q_cmd_o
);
  sha2c_pkg::cmd_t mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, rp_q;
  logic       push;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_cmd_o    = mem_q[rp_q];

  always_comb begin
    cnt_d = cnt_q + 2'(push) - 2'(q_pop_i && q_valid_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wp_q <= !wp_q;
      if (q_pop_i && q_valid_o) rp_q <= !rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= cmd_i;
  end
endmodule

// File: rtl/sha2c_keysched.sv
// key schedule: expands sixteen key words to 64 round keys, one per cycle
// depends on sha2c_pkg
`timescale 1ns / 1ps
module sha2c_keysched (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [511:0] key_i,
  output logic        busy_o,
  input  logic [5:0]  rd_idx_i,
  output logic [31:0] rd_key_o
);
  logic [31:0] win_q [16];
  logic [31:0] rk_mem [64];
  logic [6:0]  cnt_q;
  logic        busy_q;
  logic [31:0] w_new;
  logic [5:0]  widx;

  assign busy_o = busy_q;
  assign widx   = cnt_q[5:0];
  assign w_new  = (cnt_q < 7'd16) ? key_i[511 - 32*widx -: 32]
                : win_q[0] + sha2c_pkg::ss0(win_q[1]) + win_q[9]
                  + sha2c_pkg::ss1(win_q[14]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i && !busy_q) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 7'd1;
      if (cnt_q == 7'd63) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
      win_q[15] <= w_new;
      rk_mem[widx] <= w_new + sha2c_pkg::rc(widx);
    end
    rd_key_o <= rk_mem[rd_idx_i];
  end
endmodule

// File: rtl/sha2c_core.sv
// back end: 64-round shacal-2 datapath with cbc chaining and output register
// depends on sha2c_pkg and shacal2_block_cipher_cbc_defines.svh
`timescale 1ns / 1ps
`include "shacal2_block_cipher_cbc_defines.svh"
module sha2c_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  output logic            q_pop_o,
  input  sha2c_pkg::cmd_t q_cmd_i,
  input  logic            keys_ready_i,
  output logic            ks_start_o,
  input  logic            ks_busy_i,
  output logic [5:0]      rd_idx_o,
  input  logic [31:0]     rd_key_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [255:0]    out_o
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StKey  = 3'd1;
  localparam logic [2:0] StPre  = 3'd2;
  localparam logic [2:0] StRun  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0]   st_q;
  logic [31:0]  s_q [8];
  logic [5:0]   r_q;
  logic         dec_q, cbc_q;
  logic [255:0] blk_q, chain_q, res;
  logic [31:0]  t1, t2, dt1, dd, dh;
  logic         ov_q;
  logic [255:0] st_flat;

  // key index read in the cycle before the round that uses it
  assign rd_idx_o = (st_q == StPre) ? (dec_q ? 6'd63 : 6'd0)
                  : (dec_q ? r_q - 6'd1 : r_q + 6'd1);

  assign t1  = s_q[7] + sha2c_pkg::bs1(s_q[4]) + sha2c_pkg::ch(s_q[4], s_q[5], s_q[6])
             + rd_key_i;
  assign t2  = sha2c_pkg::bs0(s_q[0]) + sha2c_pkg::maj(s_q[0], s_q[1], s_q[2]);
  assign dt1 = s_q[0] - (sha2c_pkg::bs0(s_q[1]) + sha2c_pkg::maj(s_q[1], s_q[2], s_q[3]));
  assign dd  = s_q[4] - dt1;
  assign dh  = dt1 - sha2c_pkg::bs1(s_q[5]) - sha2c_pkg::ch(s_q[5], s_q[6], s_q[7])
             - rd_key_i;

  always_comb begin
    for (int i = 0; i < 8; i++) st_flat[255 - 32*i -: 32] = s_q[i];
    res = (dec_q && cbc_q) ? (st_flat ^ chain_q) : st_flat;
  end

  assign q_pop_o     = (st_q == StIdle) && q_valid_i && keys_ready_i && !ov_q;
  assign ks_start_o  = (st_q == StIdle) && q_valid_i && !keys_ready_i;
  assign out_valid_o = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      ov_q    <= 1'b0;
      chain_q <= '0;
      r_q     <= '0;
    end else begin
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      unique case (st_q)
        StIdle: begin
          if (ks_start_o) st_q <= StKey;
          else if (q_pop_o) begin
            st_q <= StPre;
            if (q_cmd_i.start)
              chain_q <= {q_cmd_i.v0, q_cmd_i.v1, q_cmd_i.v2, q_cmd_i.v3};
          end
        end
        StKey: if (!ks_busy_i && keys_ready_i) st_q <= StIdle;
        StPre: begin
          st_q <= StRun;
          r_q  <= dec_q ? 6'd63 : 6'd0;
        end
        StRun: begin
          r_q <= rd_idx_o;
          if (r_q == (dec_q ? 6'd0 : 6'd63)) st_q <= StOut;
        end
        StOut: begin
          if (!ov_q) begin
            ov_q <= 1'b1;
            st_q <= StIdle;
            if (cbc_q) chain_q <= dec_q ? blk_q : st_flat;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && q_pop_o) begin
      logic [255:0] b;
      logic [255:0] c;
      b = {q_cmd_i.d0, q_cmd_i.d1, q_cmd_i.d2, q_cmd_i.d3};
      c = q_cmd_i.start ? {q_cmd_i.v0, q_cmd_i.v1, q_cmd_i.v2, q_cmd_i.v3} : chain_q;
      dec_q <= q_cmd_i.dec;
      cbc_q <= q_cmd_i.cbc;
      blk_q <= b;
      if (!q_cmd_i.dec && q_cmd_i.cbc) b = b ^ c;
      for (int i = 0; i < 8; i++) s_q[i] <= b[255 - 32*i -: 32];
    end else if (st_q == StRun) begin
      if (!dec_q) begin
        s_q[7] <= s_q[6]; s_q[6] <= s_q[5]; s_q[5] <= s_q[4];
        s_q[4] <= s_q[3] + t1;
        s_q[3] <= s_q[2]; s_q[2] <= s_q[1]; s_q[1] <= s_q[0];
        s_q[0] <= t1 + t2;
      end else begin
        s_q[0] <= s_q[1]; s_q[1] <= s_q[2]; s_q[2] <= s_q[3]; s_q[3] <= dd;
        s_q[4] <= s_q[5]; s_q[5] <= s_q[6]; s_q[6] <= s_q[7]; s_q[7] <= dh;
      end
    end
    if (st_q == StOut && !ov_q) out_o <= res;
  end

  `SHA_ASSERT(a_pop_idle, clk_i, rst_ni, q_pop_o |-> st_q == StIdle)
  `SHA_ASSERT(a_keys_before_pop, clk_i, rst_ni, q_pop_o |-> keys_ready_i)
  `SHA_ASSERT(a_run_to_out, clk_i, rst_ni,
              (st_q == StRun && r_q == 6'd63 && !dec_q) |=> st_q == StOut)
endmodule

// File: rtl/shacal2_block_cipher_cbc.sv
// shacal-2 block cipher with cbc chaining, top level
// blocks are processed one at a time by the single shared round unit (one round
// per cycle); the first block after any key write waits for key expansion first
// reset: async active low; clears key regs, chain value, queue and key-ready flag
// depends on sha2c_pkg, sha2c_front, sha2c_keysched, sha2c_core
`timescale 1ns / 1ps
`include "shacal2_block_cipher_cbc_defines.svh"
module shacal2_block_cipher_cbc (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic        use_chaining_i,
  input  logic        start_chain_i,
  input  logic [63:0] data_0_i,
  input  logic [63:0] data_1_i,
  input  logic [63:0] data_2_i,
  input  logic [63:0] data_3_i,
  input  logic [63:0] iv_0_i,
  input  logic [63:0] iv_1_i,
  input  logic [63:0] iv_2_i,
  input  logic [63:0] iv_3_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] out_0_o,
  output logic [63:0] out_1_o,
  output logic [63:0] out_2_o,
  output logic [63:0] out_3_o
);
  // key registers, big-endian words
  logic [63:0] key_q [8];
  logic        keys_ready_q;
  logic [511:0] key_flat;
  sha2c_pkg::cmd_t in_cmd, q_cmd;
  logic q_valid, q_pop, ks_start, ks_busy, ks_busy_q;
  logic [5:0]  rd_idx;
  logic [31:0] rd_key;
  logic [255:0] res;

  always_comb begin
    for (int i = 0; i < 8; i++) key_flat[511 - 64*i -: 64] = key_q[i];
  end

  // any key write drops the expanded schedule; the falling edge of busy sets it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) key_q[i] <= '0;
      keys_ready_q <= 1'b0;
      ks_busy_q    <= 1'b0;
    end else begin
      ks_busy_q <= ks_busy;
      if (cfg_we_i) begin
        key_q[cfg_idx_i] <= cfg_wdata_i;
        keys_ready_q <= 1'b0;
      end else if (ks_busy_q && !ks_busy) begin
        keys_ready_q <= 1'b1;
      end
    end
  end

  assign in_cmd = '{dec: func_i, cbc: use_chaining_i, start: start_chain_i,
                    d0: data_0_i, d1: data_1_i, d2: data_2_i, d3: data_3_i,
                    v0: iv_0_i, v1: iv_1_i, v2: iv_2_i, v3: iv_3_i};

  // front: queue beats
  sha2c_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i(in_cmd),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_cmd_o(q_cmd)
  );

  // round key store and expander
  sha2c_keysched u_ks (
    .clk_i, .rst_ni, .start_i(ks_start), .key_i(key_flat), .busy_o(ks_busy),
    .rd_idx_i(rd_idx), .rd_key_o(rd_key)
  );

  // back: round engine and chaining
  sha2c_core u_core (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_cmd_i(q_cmd),
    .keys_ready_i(keys_ready_q), .ks_start_o(ks_start), .ks_busy_i(ks_busy),
    .rd_idx_o(rd_idx), .rd_key_i(rd_key),
    .out_valid_o, .out_stall_i, .out_o(res)
  );

  assign out_0_o = res[255:192];
  assign out_1_o = res[191:128];
  assign out_2_o = res[127:64];
  assign out_3_o = res[63:0];

  `SHA_ASSERT(a_cfg_clears_ready, clk_i, rst_ni, cfg_we_i |=> !keys_ready_q)
  `SHA_ASSERT(a_no_pop_wo_keys, clk_i, rst_ni, q_pop |-> keys_ready_q)
  `SHA_ASSERT(a_ready_after_ks, clk_i, rst_ni,
              (ks_busy_q && !ks_busy && !cfg_we_i) |=> keys_ready_q)
endmodule
